@@ design/lrupr_pkg.sv @@
// Shared types and constants of the LRU page replacement tracker.
package lrupr_pkg;

  localparam int FRAME_SLOTS = 16;
  localparam int SLOT_W      = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int RANK_W      = SLOT_W;
  localparam int CNT_W       = $clog2(FRAME_SLOTS + 1);

  localparam int PAGE_W      = 16;
  localparam int FAULT_W     = 32;
  localparam int CFG_W       = 5;
  localparam int SLOT_OUT_W  = 4;
  localparam int ADDR_W      = 3;
  localparam int APB_DATA_W  = 32;

  localparam int S_TDATA_W   = 16;
  localparam int M_FIELDS_W  = 1 + SLOT_OUT_W + 1 + PAGE_W + FAULT_W;
  localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

  localparam logic [ADDR_W-3:0] REG_FRAMES_IN_USE = '0;
  localparam logic [CFG_W-1:0]  FRAMES_RESET      = CFG_W'(3);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SRCH,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_TOUCH,
    UPD_PLACE,
    UPD_CLEAR
  } upd_op_e;

  // Search record that walks the row of cells, one cell a cycle.
  typedef struct packed {
    logic              vld;
    logic [PAGE_W-1:0] page;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic [RANK_W-1:0] hit_rank;
    logic              empty_found;
    logic [SLOT_W-1:0] empty_slot;
    logic [RANK_W-1:0] best_rank;
    logic [SLOT_W-1:0] best_slot;
    logic [PAGE_W-1:0] best_page;
  } srch_t;

  // Update broadcast to every cell once the search has finished.
  typedef struct packed {
    upd_op_e           op;
    logic [SLOT_W-1:0] slot;
    logic [RANK_W-1:0] old_rank;
    logic              wr_page;
    logic [PAGE_W-1:0] page;
  } upd_t;

endpackage

@@ design/lrupr_cell.sv @@
// One frame cell: holds a page, its valid mark and its recency rank, and searches in turn.
module lrupr_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [lrupr_pkg::SLOT_W-1:0] idx_i,
  input  logic [lrupr_pkg::CNT_W-1:0]  n_act_i,
  input  lrupr_pkg::srch_t      rec_i,
  output lrupr_pkg::srch_t      rec_o,
  input  lrupr_pkg::upd_t       upd_i
);
  import lrupr_pkg::*;

  logic              vld_q, vld_d;
  logic [RANK_W-1:0] rank_q, rank_d;
  logic [PAGE_W-1:0] page_q, page_d;
  srch_t             rec_q, rec_d;
  logic              act;
  logic              self;

  assign act  = CNT_W'(idx_i) < n_act_i;
  assign self = (idx_i == upd_i.slot);

  always_comb begin
    rec_d = rec_i;
    if (rec_i.vld && act) begin
      if (vld_q && (page_q == rec_i.page) && !rec_i.hit) begin
        rec_d.hit      = 1'b1;
        rec_d.hit_slot = idx_i;
        rec_d.hit_rank = rank_q;
      end
      if (!vld_q && !rec_i.empty_found) begin
        rec_d.empty_found = 1'b1;
        rec_d.empty_slot  = idx_i;
      end
      if ((rank_q > rec_i.best_rank) || (idx_i == '0)) begin
        rec_d.best_rank = rank_q;
        rec_d.best_slot = idx_i;
        rec_d.best_page = page_q;
      end
    end
  end

  always_comb begin
    vld_d  = vld_q;
    rank_d = rank_q;
    page_d = page_q;
    case (upd_i.op)
      UPD_CLEAR: begin
        vld_d  = 1'b0;
        rank_d = '0;
      end
      UPD_TOUCH: begin
        if (vld_q && (rank_q < upd_i.old_rank)) begin
          rank_d = rank_q + RANK_W'(1);
        end
        if (self) begin
          rank_d = '0;
          if (upd_i.wr_page) begin
            page_d = upd_i.page;
          end
        end
      end
      UPD_PLACE: begin
        if (vld_q) begin
          rank_d = rank_q + RANK_W'(1);
        end
        if (self) begin
          vld_d  = 1'b1;
          rank_d = '0;
          page_d = upd_i.page;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      rank_q <= '0;
      rec_q  <= '0;
    end else begin
      vld_q  <= vld_d;
      rank_q <= rank_d;
      rec_q  <= rec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  assign rec_o = rec_q;

endmodule

@@ design/lru_page_replacement_top.sv @@
// Top level of the LRU page replacement tracker: stream ports, APB register, control.
// A beat is taken only in idle; its search record walks the row of frame cells one cell a cycle,
// the finished record is captured, then the update is applied and the result registered once the
// output register is free or draining; only then is the next beat accepted.
// Reset: all frames empty, ranks and fault count zero, frames_in_use 3, output empty.
module lru_page_replacement_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [lrupr_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // page_number
  input  logic                             s_axis_tlast,   // end_of_string
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // page_hit, frame_slot, evicted_valid, evicted_page, fault_total, zero fill
  output logic [lrupr_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lrupr_pkg::ADDR_W-1:0]     paddr,
  input  logic [lrupr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lrupr_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready
);
  import lrupr_pkg::*;

  state_e               st_q, st_d;
  logic [CFG_W-1:0]     cfg_q;
  logic [CNT_W-1:0]     n_act;
  logic [FAULT_W-1:0]   fault_q, fault_d, fault_new;
  logic                 last_q;
  srch_t                fin_q, fin_d;
  srch_t                chain [FRAME_SLOTS+1];
  logic [FRAME_SLOTS-1:0] chain_vld;
  upd_t                 upd;
  logic                 m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;
  logic                 accept;
  logic                 emit;
  logic                 cfg_wr;
  logic                 hit;
  logic                 evict;
  logic [SLOT_W-1:0]    slot;
  logic [PAGE_W-1:0]    ev_page;

  // Register port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= FRAMES_RESET;
    end else if (cfg_wr && (paddr[ADDR_W-1:2] == REG_FRAMES_IN_USE)) begin
      cfg_q <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1:2] == REG_FRAMES_IN_USE) begin
      prdata[CFG_W-1:0] = cfg_q;
    end
  end

  always_comb begin
    if (cfg_q == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(cfg_q) > FRAME_SLOTS) begin
      n_act = CNT_W'(FRAME_SLOTS);
    end else begin
      n_act = CNT_W'(cfg_q);
    end
  end

  // Row of frame cells.
  assign s_axis_tready = (st_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    chain[0]      = '0;
    chain[0].vld  = accept;
    chain[0].page = s_axis_tdata[PAGE_W-1:0];
  end

  for (genvar g = 0; g < FRAME_SLOTS; g++) begin : g_cell
    lrupr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (SLOT_W'(g)),
      .n_act_i (n_act),
      .rec_i   (chain[g]),
      .rec_o   (chain[g+1]),
      .upd_i   (upd)
    );
    assign chain_vld[g] = chain[g+1].vld;
  end

  // Outcome of a finished search.
  always_comb begin
    hit     = fin_q.hit;
    evict   = 1'b0;
    ev_page = '0;
    upd     = '0;
    upd.op  = UPD_NONE;
    if (fin_q.hit) begin
      slot         = fin_q.hit_slot;
      upd.op       = UPD_TOUCH;
      upd.old_rank = fin_q.hit_rank;
    end else if (fin_q.empty_found) begin
      slot   = fin_q.empty_slot;
      upd.op = UPD_PLACE;
    end else begin
      slot         = fin_q.best_slot;
      evict        = 1'b1;
      ev_page      = fin_q.best_page;
      upd.op       = UPD_TOUCH;
      upd.old_rank = fin_q.best_rank;
      upd.wr_page  = 1'b1;
    end
    upd.slot = slot;
    upd.page = fin_q.page;
    if (last_q) begin
      upd.op = UPD_CLEAR;
    end
    if (!emit) begin
      upd.op = UPD_NONE;
    end
  end

  assign emit = (st_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  always_comb begin
    if (hit || (fault_q == '1)) begin
      fault_new = fault_q;
    end else begin
      fault_new = fault_q + FAULT_W'(1);
    end
  end

  always_comb begin
    st_d      = st_q;
    fin_d     = fin_q;
    fault_d   = fault_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          st_d = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (chain[FRAME_SLOTS].vld) begin
          fin_d = chain[FRAME_SLOTS];
          st_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (emit) begin
          m_valid_d = 1'b1;
          m_data_d  = M_TDATA_W'({fault_new, ev_page, evict, SLOT_OUT_W'(slot), hit});
          fault_d   = last_q ? '0 : fault_new;
          st_d      = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      fault_q   <= '0;
      m_valid_q <= 1'b0;
      fin_q     <= '0;
    end else begin
      st_q      <= st_d;
      fault_q   <= fault_d;
      m_valid_q <= m_valid_d;
      fin_q     <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    if (accept) begin
      last_q <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // At most one search record is ever in flight along the row.
  a_one_record : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(chain_vld) <= 1)
    else $error("more than one search record in the cell row");

  // A new beat is only taken when the row is empty.
  a_idle_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (chain_vld == '0))
    else $error("input accepted while a search is in flight");

  // A finished search is loaded only into a free or draining output register.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DONE && st_d == ST_IDLE) |-> (!m_valid_q || m_axis_tready))
    else $error("result overwrote an untaken beat");

endmodule

@@ verif/tb_lru_page_replacement_top.sv @@
// Self-checking testbench for lru_page_replacement_top: directed table, random runs, APB phases.
module tb_lru_page_replacement_top;
  import lrupr_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_FRAMES = {REG_FRAMES_IN_USE, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_UNUSED = 3'd4;
  localparam int SETTLE_CYCLES  = FRAME_SLOTS + 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 15;
  localparam int PHASE_ITEMS    = 97;
  localparam int DIR_ROWS       = 20;
  localparam int WS_MAX         = 40;
  // Frame settings of the random phases, first phase in the lowest bits.
  localparam logic [PHASES*CFG_W-1:0] CFG_PLAN = {
    5'd0, 5'd31, 5'd12, 5'd4, 5'd16, 5'd5, 5'd1, 5'd8,
    5'd17, 5'd2, 5'd3, 5'd31, 5'd16, 5'd1, 5'd0
  };

  typedef struct packed {
    logic [M_TDATA_W-M_FIELDS_W-1:0] pad;
    logic [FAULT_W-1:0]              fault_total;
    logic [PAGE_W-1:0]               evicted_page;
    logic                            evicted_valid;
    logic [SLOT_OUT_W-1:0]           frame_slot;
    logic                            page_hit;
  } lru_result_t;

  typedef enum logic {ROW_REF, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       wdata;
    logic [PAGE_W-1:0] page;
    logic              eos;
    logic              typed_exp;
    lru_result_t       want;
  } dir_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PULSE, RX_CHOKE} rx_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;  // page_number
  logic                  s_axis_tlast = 1'b0;  // end_of_string
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // page_hit, frame_slot, evicted_valid, evicted_page, fault_total, zero fill
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  lru_page_replacement_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [PAGE_W-1:0]  pg_tab   [FRAME_SLOTS];
  logic               pg_valid [FRAME_SLOTS];
  logic [RANK_W-1:0]  pg_age   [FRAME_SLOTS];
  logic [FAULT_W-1:0] faults;
  logic [CFG_W-1:0]   frames_cfg;
  lru_result_t        exp_results [$];
  int                 errs = 0;
  int                 burst_left = 0;
  int                 idle_cycles = 0;

  function automatic void lru_clear();
    for (int i = 0; i < FRAME_SLOTS; i++) begin
      pg_tab[i]   = '0;
      pg_valid[i] = 1'b0;
      pg_age[i]   = '0;
    end
    faults = '0;
  endfunction

  function automatic void age_touch(int s);
    logic [RANK_W-1:0] old;
    old = pg_age[s];
    for (int i = 0; i < FRAME_SLOTS; i++)
      if (pg_valid[i] && pg_age[i] < old) pg_age[i]++;
    pg_age[s] = '0;
  endfunction

  function automatic lru_result_t lru_lookup(logic [PAGE_W-1:0] page, logic eos);
    lru_result_t       r;
    int                n;
    int                slot;
    logic              hit;
    logic              placed;
    logic [RANK_W-1:0] best;
    r = '0;
    n = int'(frames_cfg);
    if (n < 1) n = 1;
    if (n > FRAME_SLOTS) n = FRAME_SLOTS;
    hit = 1'b0;
    placed = 1'b0;
    slot = 0;
    for (int i = 0; i < n; i++)
      if (!hit && pg_valid[i] && pg_tab[i] == page) begin
        hit = 1'b1;
        slot = i;
      end
    if (hit) begin
      age_touch(slot);
    end else begin
      if (faults != '1) faults++;
      for (int i = 0; i < n; i++)
        if (!placed && !pg_valid[i]) begin
          placed = 1'b1;
          slot = i;
        end
      if (placed) begin
        for (int i = 0; i < FRAME_SLOTS; i++)
          if (pg_valid[i]) pg_age[i]++;
        pg_valid[slot] = 1'b1;
        pg_tab[slot]   = page;
        pg_age[slot]   = '0;
      end else begin
        best = '0;
        slot = 0;
        for (int i = 0; i < n; i++)
          if (pg_age[i] > best) begin
            best = pg_age[i];
            slot = i;
          end
        r.evicted_valid = 1'b1;
        r.evicted_page  = pg_tab[slot];
        age_touch(slot);
        pg_tab[slot] = page;
      end
    end
    r.page_hit    = hit;
    r.frame_slot  = slot[SLOT_OUT_W-1:0];
    r.fault_total = faults;
    if (eos) lru_clear();
    return r;
  endfunction

  function automatic lru_result_t mk_result(logic hit, logic [SLOT_OUT_W-1:0] slot, logic ev,
                                            logic [PAGE_W-1:0] evp, logic [FAULT_W-1:0] ft);
    lru_result_t r;
    r = '0;
    r.page_hit      = hit;
    r.frame_slot    = slot;
    r.evicted_valid = ev;
    r.evicted_page  = evp;
    r.fault_total   = ft;
    return r;
  endfunction

  function automatic void cmp_field(string fname, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
      errs++;
    end
  endfunction

  task automatic send_page(input logic [PAGE_W-1:0] page, input logic eos,
                           input logic typed_exp, input lru_result_t want);
    lru_result_t pred;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= page;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = lru_lookup(page, eos);
    exp_results.push_back(typed_exp ? want : pred);
    burst_left--;
  endtask

  task automatic check_frames_reg();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_FRAMES;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cmp_field("frames_in_use readback", {{(64-CFG_W){1'b0}}, frames_cfg}, 64'(prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_write(input logic [ADDR_W-1:0] a, input logic [31:0] d);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (exp_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (a == ADDR_FRAMES) frames_cfg = d[CFG_W-1:0];
    @(posedge clk_i);
    check_frames_reg();
  endtask

  rx_mode_e   rx_mode = RX_OPEN;
  int         rx_left = 0;
  int         rx_hold = 0;
  logic [1:0] rx_tick = '0;

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(50, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_tick <= rx_tick + 2'd1;
    case (rx_mode)
      RX_OPEN: begin
        m_axis_tready <= 1'b1;
      end
      RX_COIN: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      RX_PULSE: begin
        m_axis_tready <= (rx_tick == 2'd0);
      end
      default: begin
        if (rx_hold == 0) begin
          m_axis_tready <= !m_axis_tready;
          rx_hold <= m_axis_tready ? $urandom_range(10, 40) : $urandom_range(1, 6);
        end else begin
          rx_hold <= rx_hold - 1;
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    lru_result_t got;
    lru_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (exp_results.size() == 0) begin
        $display("%0t: result %0h arrived with nothing expected", $time, got);
        errs++;
      end else begin
        want = exp_results.pop_front();
        cmp_field("page_hit", 64'(want.page_hit), 64'(got.page_hit));
        cmp_field("frame_slot", 64'(want.frame_slot), 64'(got.frame_slot));
        cmp_field("evicted_valid", 64'(want.evicted_valid), 64'(got.evicted_valid));
        cmp_field("evicted_page", 64'(want.evicted_page), 64'(got.evicted_page));
        cmp_field("fault_total", 64'(want.fault_total), 64'(got.fault_total));
        cmp_field("zero fill", 64'(want.pad), 64'(got.pad));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_lru_page_replacement_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  dir_row_t dir_tab [DIR_ROWS];

  initial begin
    logic [PAGE_W-1:0] ws [WS_MAX];
    logic [PAGE_W-1:0] pg;
    logic              eos;
    logic [31:0]       d;
    int                sent;
    int                ws_n;
    int                run_len;
    int                n_eff;

    lru_clear();
    frames_cfg = FRAMES_RESET;

    dir_tab[0]  = '{ROW_REF, ADDR_FRAMES, 32'd0, 16'h0000, 1'b0, 1'b1,
                    mk_result(1'b0, 4'd0, 1'b0, 16'h0000, 32'd1)};
    dir_tab[1]  = '{ROW_REF, ADDR_FRAMES, 32'd0, 16'hFFFF, 1'b0, 1'b1,
                    mk_result(1'b0, 4'd1, 1'b0, 16'h0000, 32'd2)};
    dir_tab[2]  = '{ROW_REF, ADDR_FRAMES, 32'd0, 16'h0000, 1'b0, 1'b1,
                    mk_result(1'b1, 4'd0, 1'b0, 16'h0000, 32'd2)};
    dir_tab[3]  = '{ROW_REF, ADDR_FRAMES, 32'd0, 16'h1234, 1'b0, 1'b1,
                    mk_result(1'b0, 4'd2, 1'b0, 16'h0000, 32'd3)};
    dir_tab[4]  = '{ROW_REF, ADDR_FRAMES, 32'd0, 16'h8001, 1'b0, 1'b1,
                    mk_result(1'b0, 4'd1, 1'b1, 16'hFFFF, 32'd4)};
    dir_tab[5]  = '{ROW_REF, ADDR_FRAMES, 32'd0, 16'hFFFF, 1'b1, 1'b1,
                    mk_result(1'b0, 4'd0, 1'b1, 16'h0000, 32'd5)};
    dir_tab[6]  = '{ROW_REF, ADDR_FRAMES, 32'd0, 16'hFFFF, 1'b0, 1'b1,
                    mk_result(1'b0, 4'd0, 1'b0, 16'h0000, 32'd1)};
    dir_tab[7]  = '{ROW_REF, ADDR_FRAMES, 32'd0, 16'h5555, 1'b0, 1'b0, '0};
    dir_tab[8]  = '{ROW_CFG, ADDR_FRAMES, 32'd0, 16'h0000, 1'b0, 1'b0, '0};
    dir_tab[9]  = '{ROW_REF, ADDR_FRAMES, 32'd0, 16'h5555, 1'b0, 1'b0, '0};
    dir_tab[10] = '{ROW_REF, ADDR_FRAMES, 32'd0, 16'h5555, 1'b0, 1'b0, '0};
    dir_tab[11] = '{ROW_CFG, ADDR_FRAMES, 32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b0, '0};
    dir_tab[12] = '{ROW_REF, ADDR_FRAMES, 32'd0, 16'h5555, 1'b0, 1'b0, '0};
    dir_tab[13] = '{ROW_REF, ADDR_FRAMES, 32'd0, 16'hAAAA, 1'b0, 1'b0, '0};
    dir_tab[14] = '{ROW_CFG, ADDR_UNUSED, 32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b0, '0};
    dir_tab[15] = '{ROW_REF, ADDR_FRAMES, 32'd0, 16'h0001, 1'b1, 1'b0, '0};
    dir_tab[16] = '{ROW_CFG, ADDR_FRAMES, 32'd1, 16'h0000, 1'b0, 1'b0, '0};
    dir_tab[17] = '{ROW_REF, ADDR_FRAMES, 32'd0, 16'h00FF, 1'b0, 1'b0, '0};
    dir_tab[18] = '{ROW_REF, ADDR_FRAMES, 32'd0, 16'h7F00, 1'b0, 1'b0, '0};
    dir_tab[19] = '{ROW_REF, ADDR_FRAMES, 32'd0, 16'h7F00, 1'b1, 1'b0, '0};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_frames_reg();

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].kind == ROW_CFG) begin
        reg_write(dir_tab[r].addr, dir_tab[r].wdata);
      end else begin
        send_page(dir_tab[r].page, dir_tab[r].eos, dir_tab[r].typed_exp, dir_tab[r].want);
      end
    end

    // Runs of references drawn from a small working set, so that hits, fills and
    // evictions all occur; a phase may end mid-run, leaving pages beyond a lowered count.
    for (int p = 0; p < PHASES; p++) begin
      d = $urandom();
      d[CFG_W-1:0] = CFG_PLAN[p*CFG_W +: CFG_W];
      reg_write(ADDR_FRAMES, d);
      if (p == PHASES / 2) reg_write(ADDR_UNUSED, $urandom());
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        n_eff = int'(frames_cfg);
        if (n_eff < 1) n_eff = 1;
        if (n_eff > FRAME_SLOTS) n_eff = FRAME_SLOTS;
        ws_n = $urandom_range(1, (2 * n_eff + 2 > WS_MAX) ? WS_MAX : 2 * n_eff + 2);
        for (int k = 0; k < ws_n; k++) ws[k] = 16'($urandom_range(0, 65535));
        run_len = $urandom_range(1, 60);
        for (int j = 0; j < run_len && sent < PHASE_ITEMS; j++) begin
          pg  = ($urandom_range(0, 99) < 85) ? ws[$urandom_range(0, ws_n - 1)]
                                             : 16'($urandom_range(0, 65535));
          eos = (j == run_len - 1) || ($urandom_range(0, 99) == 0);
          send_page(pg, eos, 1'b0, '0);
          sent++;
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errs == 0) begin
      $display("tb_lru_page_replacement_top: PASS");
    end else begin
      $display("tb_lru_page_replacement_top: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/lrupr_pkg.sv
design/lrupr_cell.sv
design/lru_page_replacement_top.sv
verif/tb_lru_page_replacement_top.sv
